[design/mlr_pkg.sv]
// Shared types and constants for the midpoint line rasteriser.
package mlr_pkg;

	// Width of every coordinate field on the stream buses
	localparam int FIELD_BITS    = 6;
	// Input word: start_x, start_y, end_x, end_y from the lowest bit up
	localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
	// Output word: pixel_x, pixel_y, zero fill to whole bytes
	localparam int OUT_DATA_BITS = ((2 * FIELD_BITS + 7) / 8) * 8;

	// Bit offsets of the fields inside the input word
	localparam int SX_LSB = 0;
	localparam int SY_LSB = FIELD_BITS;
	localparam int EX_LSB = 2 * FIELD_BITS;
	localparam int EY_LSB = 3 * FIELD_BITS;

endpackage

[design/midpoint_line_rasterizer.sv]
// Midpoint line rasteriser: one endpoint pair in, one pixel word per cycle out unless the output stalls.
// An accepted endpoint word seeds the decision in ST_INIT; ST_RUN then loads the first pixel word.
// A line of N pixels (1 to 2^COORD_BITS) is sent one pixel per cycle through the
// shared decision adder, slower under back-pressure.
// s_axis_tready is high only while idle; no new line is taken during a line.
// arst_n clears the sequencer and the output valid; the block then waits idle.
module midpoint_line_rasterizer import mlr_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// start_x, start_y, end_x, end_y (6 bits each, lowest bit up)
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// pixel_x, pixel_y (6 bits each, lowest bit up), zero fill
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// last_pixel
	output logic                     m_axis_tlast
);

	localparam int C = COORD_BITS;
	localparam int D = COORD_BITS + 1;       // signed delta
	localparam int S = COORD_BITS + 2;       // minor minus major
	localparam int W = 2 * COORD_BITS + 2;   // decision value

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN
	} state_t;

	state_t                state_q;
	logic [C-1:0]          cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [D-1:0]   dx_q, dy_q;
	logic                  x_major_q;
	logic signed [S-1:0]   step_neg_q;
	logic signed [W-1:0]   dec_q;
	logic                  out_valid_q;
	logic [C-1:0]          out_x_q, out_y_q;
	logic                  out_last_q;

	logic [C-1:0]          in_sx, in_sy, in_ex, in_ey;
	logic signed [D-1:0]   in_dx, in_dy;
	logic signed [D-1:0]   major_d, minor_d, major_adj, major_half;
	logic [C-1:0]          major_cur, major_end;
	logic                  more;
	logic                  in_accept, out_load;
	logic signed [W-1:0]   add_a, add_b, add_sum;

	// Take the low coordinate bits of each field
	assign in_sx = s_axis_tdata[SX_LSB +: C];
	assign in_sy = s_axis_tdata[SY_LSB +: C];
	assign in_ex = s_axis_tdata[EX_LSB +: C];
	assign in_ey = s_axis_tdata[EY_LSB +: C];
	assign in_dx = signed'({1'b0, in_ex}) - signed'({1'b0, in_sx});
	assign in_dy = signed'({1'b0, in_ey}) - signed'({1'b0, in_sy});

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Select the major and minor axes
	assign major_d   = x_major_q ? dx_q : dy_q;
	assign minor_d   = x_major_q ? dy_q : dx_q;
	assign major_cur = x_major_q ? cur_x_q : cur_y_q;
	assign major_end = x_major_q ? end_x_q : end_y_q;
	assign more      = (major_cur < major_end);

	// Halve the major delta, truncating toward zero
	assign major_adj  = major_d + D'({1'b0, major_d[D-1]});
	assign major_half = major_adj >>> 1;

	// Shared decision adder: seed in INIT, update on every pixel step
	always_comb begin
		if (state_q == ST_INIT) begin
			add_a = W'(minor_d);
			add_b = -W'(major_half);
		end else begin
			add_a = dec_q;
			add_b = dec_q[W-1] ? W'(minor_d) : W'(step_neg_q);
		end
	end
	assign add_sum = add_a + add_b;

	// Load a pixel whenever the output register is free or being emptied
	assign out_load = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);

	// Sequencer, line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			x_major_q   <= 1'b0;
			step_neg_q  <= '0;
			dec_q       <= '0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the output word once taken
			if (m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						cur_x_q   <= in_sx;
						cur_y_q   <= in_sy;
						end_x_q   <= in_ex;
						end_y_q   <= in_ey;
						dx_q      <= in_dx;
						dy_q      <= in_dy;
						x_major_q <= (in_dy <= in_dx);
						state_q   <= ST_INIT;
					end
				end
				ST_INIT: begin
					dec_q      <= add_sum;
					step_neg_q <= S'(minor_d) - S'(major_d);
					state_q    <= ST_RUN;
				end
				ST_RUN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_x_q     <= cur_x_q;
						out_y_q     <= cur_y_q;
						out_last_q  <= !more;
						if (more) begin
							// advance the major axis, and the minor one on a
							// non-negative decision
							dec_q <= add_sum;
							if (x_major_q) begin
								cur_x_q <= cur_x_q + 1'b1;
								if (!dec_q[W-1]) cur_y_q <= cur_y_q + 1'b1;
							end else begin
								cur_y_q <= cur_y_q + 1'b1;
								if (!dec_q[W-1]) cur_x_q <= cur_x_q + 1'b1;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_DATA_BITS'({FIELD_BITS'(out_y_q), FIELD_BITS'(out_x_q)});

	// An accepted endpoint word closes the input until the line is done
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready && state_q == ST_INIT)
		else $error("input stayed open after an accepted endpoint word");

	// The final pixel returns the sequencer to idle
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !more) |=> s_axis_tready && m_axis_tvalid && m_axis_tlast)
		else $error("last pixel did not end the line");

	// A line only moves to pixel output after the decision is seeded
	a_run_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_RUN) |-> $past(state_q == ST_INIT))
		else $error("pixel output started without decision seed");

endmodule
